// ----- rtl/core/itf_pkg.sv -----
// ----------------------------------------------------------------------------
// itf_pkg: shared definitions for the integer text formatter
// Request opcodes, character constants, BCD sizes and the digit glyph lookup.
// ----------------------------------------------------------------------------
package itf_pkg;

	// Request opcodes as they arrive on the request channel.
	typedef enum logic [2:0] {
		OP_LITERAL  = 3'd0,
		OP_SIGNED   = 3'd1,
		OP_UNSIGNED = 3'd2,
		OP_HEX      = 3'd3,
		OP_TAB      = 3'd4
	} opcode_t;

	// Widths of the converted value.
	localparam int unsigned BIN_W       = 32;
	localparam int unsigned DEC_DIGITS  = 10;
	localparam int unsigned HEX_DIGITS  = 8;
	localparam int unsigned BCD_W       = 4 * DEC_DIGITS;
	localparam int unsigned MAX_RESULTS = 11;

	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [BIN_W-1:0] bin_t;
	typedef logic [7:0]       char_t;

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_ALPHA = 8'h37;  // 'A' minus ten
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_X     = 8'h78;
	localparam char_t CH_SPACE = 8'h20;

	// Uppercase glyph for one digit of value 0 to 15.
	function automatic char_t digit_glyph(input logic [3:0] d);
		char_t base;
		base = (d < 4'd10) ? CH_ZERO : CH_ALPHA;
		return base + {4'd0, d};
	endfunction

endpackage

// ----- rtl/core/itf_req_if.sv -----
// ----------------------------------------------------------------------------
// itf_req_if: request channel
// Carries one formatting request per item under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface itf_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] number;
	logic [7:0]  literal_char;

	modport source(output valid, output opcode, output number, output literal_char,
		input ready);
	modport sink(input valid, input opcode, input number, input literal_char,
		output ready);
endinterface

// ----- rtl/core/itf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// itf_rsp_if: character channel
// Carries one output character per item, with the last one of a request marked.
// ----------------------------------------------------------------------------
interface itf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source(output valid, output out_char, output last_char, input ready);
	modport sink(input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/core/itf_dabble.sv -----
// ----------------------------------------------------------------------------
// itf_dabble: one shift-and-add-3 step of binary to BCD conversion
// Corrects every BCD digit that is five or more, then shifts the BCD and
// binary words left together by one bit.
// ----------------------------------------------------------------------------
module itf_dabble (
	input  itf_pkg::bcd_t bcd,
	input  itf_pkg::bin_t bin,
	output itf_pkg::bcd_t bcd_next,
	output itf_pkg::bin_t bin_next
);

	itf_pkg::bcd_t adj;

	// Add three to each digit that would overflow past nine after the shift.
	always_comb begin
		for (int i = 0; i < itf_pkg::DEC_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
				: bcd[4*i +: 4];
		end
	end

	// Shift the top binary bit into the BCD word.
	assign bcd_next = {adj[itf_pkg::BCD_W-2:0], bin[itf_pkg::BIN_W-1]};
	assign bin_next = {bin[itf_pkg::BIN_W-2:0], 1'b0};

endmodule

// ----- rtl/core/integer_text_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_text_formatter: binary to ASCII decimal and hex text
// Turns one request into a run of characters, most significant first.
// ----------------------------------------------------------------------------
// One request is taken at a time; the request channel is ready only while the
// block is idle. A decimal request emits the minus sign first for a negative
// signed value, then runs shift-and-add-3 over every bit through a single BCD
// step unit, then skips leading zero digits (at most 9), then emits up to 10
// digits. A hex request skips the conversion: it emits the 2 prefix characters,
// skips leading zero digits and emits up to 8 digits. A literal emits one
// character and a tab TAB_WIDTH spaces, at most 11. Characters leave through a
// single output register, so a stalled consumer holds the sequencer, and
// opcodes 5 to 7 are consumed without producing any character.
// ----------------------------------------------------------------------------
module integer_text_formatter #(
	parameter int unsigned TAB_WIDTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	itf_req_if.sink   req,
	itf_rsp_if.source rsp
);

	localparam int unsigned TabCount = (TAB_WIDTH > itf_pkg::MAX_RESULTS) ?
		itf_pkg::MAX_RESULTS : TAB_WIDTH;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_LIT     = 9'b000000010,
		ST_SIGN    = 9'b000000100,
		ST_CONV    = 9'b000001000,
		ST_PREFIX0 = 9'b000010000,
		ST_PREFIXX = 9'b000100000,
		ST_SKIP    = 9'b001000000,
		ST_DIGIT   = 9'b010000000,
		ST_TAB     = 9'b100000000
	} state_t;

	state_t        state_q;
	itf_pkg::bcd_t bcd_q;
	itf_pkg::bin_t bin_q;
	itf_pkg::bcd_t bcd_next;
	itf_pkg::bin_t bin_next;
	logic [4:0]    conv_cnt_q;
	logic [3:0]    idx_q;
	logic [3:0]    tab_cnt_q;
	itf_pkg::char_t lit_q;
	logic [3:0]    cur_digit;

	logic           ovalid_q;
	itf_pkg::char_t ochar_q;
	logic           olast_q;
	logic           can_push;
	logic           push;
	itf_pkg::char_t push_char;
	logic           push_last;
	logic           accept;

	// Shared BCD step unit.
	itf_dabble u_dabble (
		.bcd     (bcd_q),
		.bin     (bin_q),
		.bcd_next(bcd_next),
		.bin_next(bin_next)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign can_push  = !ovalid_q || rsp.ready;
	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

	// Character offered by the current state.
	always_comb begin
		push      = 1'b0;
		push_char = itf_pkg::CH_SPACE;
		push_last = 1'b0;
		case (state_q)
			ST_LIT: begin
				push      = can_push;
				push_char = lit_q;
				push_last = 1'b1;
			end
			ST_SIGN: begin
				push      = can_push;
				push_char = itf_pkg::CH_MINUS;
			end
			ST_PREFIX0: begin
				push      = can_push;
				push_char = itf_pkg::CH_ZERO;
			end
			ST_PREFIXX: begin
				push      = can_push;
				push_char = itf_pkg::CH_X;
			end
			ST_DIGIT: begin
				push      = can_push;
				push_char = itf_pkg::digit_glyph(cur_digit);
				push_last = (idx_q == 4'd0);
			end
			ST_TAB: begin
				push      = can_push;
				push_char = itf_pkg::CH_SPACE;
				push_last = (tab_cnt_q == 4'd1);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			conv_cnt_q <= '0;
			idx_q      <= '0;
			tab_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.opcode)
							itf_pkg::OP_LITERAL: begin
								state_q <= ST_LIT;
							end
							itf_pkg::OP_SIGNED: begin
								state_q    <= req.number[itf_pkg::BIN_W-1] ? ST_SIGN
									: ST_CONV;
								conv_cnt_q <= '0;
							end
							itf_pkg::OP_UNSIGNED: begin
								state_q    <= ST_CONV;
								conv_cnt_q <= '0;
							end
							itf_pkg::OP_HEX: begin
								state_q <= ST_PREFIX0;
								idx_q   <= 4'(itf_pkg::HEX_DIGITS - 1);
							end
							itf_pkg::OP_TAB: begin
								state_q   <= (TabCount == 0) ? ST_IDLE : ST_TAB;
								tab_cnt_q <= 4'(TabCount);
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_LIT: begin
					if (push) state_q <= ST_IDLE;
				end
				ST_SIGN: begin
					if (push) state_q <= ST_CONV;
				end
				ST_CONV: begin
					conv_cnt_q <= conv_cnt_q + 5'd1;
					if (conv_cnt_q == 5'(itf_pkg::BIN_W - 1)) begin
						state_q <= ST_SKIP;
						idx_q   <= 4'(itf_pkg::DEC_DIGITS - 1);
					end
				end
				ST_PREFIX0: begin
					if (push) state_q <= ST_PREFIXX;
				end
				ST_PREFIXX: begin
					if (push) state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (idx_q != 4'd0 && cur_digit == 4'd0) begin
						idx_q <= idx_q - 4'd1;
					end else begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (push) begin
						if (idx_q == 4'd0) state_q <= ST_IDLE;
						else idx_q <= idx_q - 4'd1;
					end
				end
				ST_TAB: begin
					if (push) begin
						tab_cnt_q <= tab_cnt_q - 4'd1;
						if (tab_cnt_q == 4'd1) state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Value registers: load on accept, step the BCD unit while converting.
	always_ff @(posedge clk) begin
		if (accept) begin
			lit_q <= req.literal_char;
			if (req.opcode == itf_pkg::OP_HEX) begin
				bcd_q <= {{(itf_pkg::BCD_W - itf_pkg::BIN_W){1'b0}}, req.number};
			end else begin
				bcd_q <= '0;
			end
			if (req.opcode == itf_pkg::OP_SIGNED && req.number[itf_pkg::BIN_W-1]) begin
				bin_q <= ~req.number + 32'd1;
			end else begin
				bin_q <= req.number;
			end
		end else if (state_q == ST_CONV) begin
			bcd_q <= bcd_next;
			bin_q <= bin_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (push) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ochar_q <= push_char;
			olast_q <= push_last;
		end
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.out_char  = ochar_q;
	assign rsp.last_char = olast_q;

endmodule

// ----- tb/integer_text_formatter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_formatter_checker: character stream scoreboard
// Watches the request and character channels. Each accepted request is
// rendered into its expected text, and each accepted character is compared
// against the oldest expected character.
// ----------------------------------------------------------------------------
module integer_text_formatter_checker #(
	parameter int unsigned TAB_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	itf_req_if          req,
	itf_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned pending_chars,
	output int unsigned requests_seen,
	output int unsigned ignored_requests,
	output int unsigned chars_checked
);

	typedef struct packed {
		itf_pkg::char_t ch;
		logic           last;
	} text_char_t;

	localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789ABCDEF";
	localparam int unsigned     DEC_RADIX    = 10;
	localparam int unsigned     HEX_RADIX    = 16;
	localparam int unsigned     REPORT_LIMIT = 10;
	// A tab never emits more spaces than the longest number does characters.
	localparam int unsigned TAB_SPACES = (TAB_WIDTH > itf_pkg::MAX_RESULTS) ?
		itf_pkg::MAX_RESULTS : TAB_WIDTH;

	// Characters still owed by the block, oldest first.
	text_char_t due_chars[$];

	// Appends the digits of value in the given radix, most significant first.
	// A zero value still yields a single zero digit.
	function automatic void append_digits(input itf_pkg::bin_t value,
		input int unsigned radix, inout itf_pkg::char_t text[$]);
		itf_pkg::char_t digits[$];
		int unsigned    d;
		do begin
			d = value % radix;
			digits.push_front(DIGIT_GLYPHS[8*(15-d) +: 8]);
			value = value / radix;
		end while (value != '0);
		foreach (digits[i]) begin
			text.push_back(digits[i]);
		end
	endfunction

	// Renders one request into the text the block should emit.
	function automatic void render_request(input logic [2:0] op, input itf_pkg::bin_t num,
		input itf_pkg::char_t lit, output itf_pkg::char_t text[$]);
		text = {};
		case (op)
			itf_pkg::OP_LITERAL: begin
				text.push_back(lit);
			end
			itf_pkg::OP_SIGNED: begin
				// Negation wraps, so the most negative value stays 2^31 as unsigned.
				if (num[itf_pkg::BIN_W-1]) begin
					text.push_back(itf_pkg::CH_MINUS);
					num = -num;
				end
				append_digits(num, DEC_RADIX, text);
			end
			itf_pkg::OP_UNSIGNED: begin
				append_digits(num, DEC_RADIX, text);
			end
			itf_pkg::OP_HEX: begin
				text.push_back(itf_pkg::CH_ZERO);
				text.push_back(itf_pkg::CH_X);
				append_digits(num, HEX_RADIX, text);
			end
			itf_pkg::OP_TAB: begin
				repeat (TAB_SPACES) text.push_back(itf_pkg::CH_SPACE);
			end
			default: begin
				// Unused opcodes are swallowed without output.
			end
		endcase
	endfunction

	// Counts a mismatch and reports the first few in detail.
	task automatic note_mismatch(input string what, input text_char_t want);
		if (fail_count < REPORT_LIMIT) begin
			$display("%0t: MISMATCH %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
				$time, what, want.ch, want.last, rsp.out_char, rsp.last_char);
		end
		fail_count <= fail_count + 1;
	endtask

	// Characters are checked before a request taken at the same edge is queued,
	// since such a character can only belong to an earlier request.
	always @(posedge clk or negedge arst_n) begin
		itf_pkg::char_t text[$];
		text_char_t     want;
		if (!arst_n) begin
			due_chars.delete();
			fail_count       <= 0;
			pending_chars    <= 0;
			requests_seen    <= 0;
			ignored_requests <= 0;
			chars_checked    <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				chars_checked <= chars_checked + 1;
				if (due_chars.size() == 0) begin
					want = '0;
					note_mismatch("character with nothing outstanding", want);
				end else begin
					want = due_chars.pop_front();
					if (rsp.out_char !== want.ch || rsp.last_char !== want.last) begin
						note_mismatch("character", want);
					end
				end
			end
			if (req.valid && req.ready) begin
				render_request(req.opcode, req.number, req.literal_char, text);
				requests_seen <= requests_seen + 1;
				if (text.size() == 0) begin
					ignored_requests <= ignored_requests + 1;
				end
				foreach (text[i]) begin
					want.ch   = text[i];
					want.last = (i == text.size() - 1);
					due_chars.push_back(want);
				end
			end
			pending_chars <= due_chars.size();
		end
	end

endmodule

// ----- tb/integer_text_formatter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_formatter_tb: testbench top for the integer text formatter
// Sends directed and random formatting requests under three idle mixes and
// long receiver hold-offs; the checker scores every character that comes out.
// ----------------------------------------------------------------------------
module integer_text_formatter_tb;

	localparam int unsigned TAB_WIDTH    = 8;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned BURST_ITEMS  = 50;
	localparam int unsigned UNUSED_PCT   = 6;

	// Opcodes the block accepts but ignores.
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	logic        clk;
	logic        arst_n = 1'b0;
	int unsigned send_idle_pct = 28;
	int unsigned recv_idle_pct = 75;
	int unsigned hold_requests = 0;
	int unsigned holdoffs_done = 0;
	int unsigned quiet_cycles  = 0;

	int unsigned fail_count;
	int unsigned pending_chars;
	int unsigned requests_seen;
	int unsigned ignored_requests;
	int unsigned chars_checked;

	itf_req_if req();
	itf_rsp_if rsp();

	integer_text_formatter #(
		.TAB_WIDTH(TAB_WIDTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	integer_text_formatter_checker #(
		.TAB_WIDTH(TAB_WIDTH)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.pending_chars   (pending_chars),
		.requests_seen   (requests_seen),
		.ignored_requests(ignored_requests),
		.chars_checked   (chars_checked)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Picks a value biased toward digit-count and sign boundaries.
	function automatic itf_pkg::bin_t draw_operand();
		itf_pkg::bin_t scale;
		scale = 32'd1;
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(99);
			2: begin
				repeat ($urandom_range(9)) scale = scale * 32'd10;
				return scale + $urandom_range(2) - 32'd1;
			end
			3: begin
				scale = scale << (4 * $urandom_range(7));
				return scale - $urandom_range(1);
			end
			4: return 32'h8000_0000 + $urandom_range(3) - $urandom_range(3);
			default: return -itf_pkg::bin_t'($urandom_range(1000, 1));
		endcase
	endfunction

	// Offers one request after a random gap and waits until it is taken.
	task automatic send_request(input logic [2:0] op, input itf_pkg::bin_t num,
		input itf_pkg::char_t lit);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.number       <= num;
		req.literal_char <= lit;
		do @(posedge clk); while (!req.ready);
	endtask

	// Random requests until the given number of non-ignored ones have gone in.
	task automatic random_burst(input int unsigned count);
		int unsigned taken;
		logic [2:0]  op;
		taken = 0;
		while (taken < count) begin
			if ($urandom_range(99) < UNUSED_PCT) begin
				op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
			end else begin
				op = 3'($urandom_range(itf_pkg::OP_TAB));
			end
			send_request(op, draw_operand(), 8'($urandom_range(255)));
			if (op <= itf_pkg::OP_TAB) begin
				taken++;
			end
		end
	endtask

	// Character receiver: random backpressure, with long hold-offs on request.
	initial begin
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoffs_done < hold_requests) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holdoffs_done++;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no item moves on either channel for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d characters still due",
				$time, QUIET_LIMIT, pending_chars);
			$display("** integer_text_formatter: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Request stimulus and verdict.
	initial begin
		req.valid        <= 1'b0;
		req.opcode       <= itf_pkg::OP_LITERAL;
		req.number       <= '0;
		req.literal_char <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender mostly busy, receiver mostly stalled.
		send_idle_pct = 28;
		recv_idle_pct = 75;

		// Literal extremes, with the unused number field toggled.
		send_request(itf_pkg::OP_LITERAL, 32'h0000_0000, 8'h00);
		send_request(itf_pkg::OP_LITERAL, 32'hFFFF_FFFF, 8'hFF);
		send_request(itf_pkg::OP_LITERAL, 32'h5555_AAAA, 8'h41);
		// Signed: zero, one, minus one, both ends of the range, a two-digit negative.
		send_request(itf_pkg::OP_SIGNED, 32'h0000_0000, 8'hFF);
		send_request(itf_pkg::OP_SIGNED, 32'h0000_0001, 8'h00);
		send_request(itf_pkg::OP_SIGNED, 32'hFFFF_FFFF, 8'h00);
		send_request(itf_pkg::OP_SIGNED, 32'h7FFF_FFFF, 8'h00);
		send_request(itf_pkg::OP_SIGNED, 32'h8000_0000, 8'h00);
		send_request(itf_pkg::OP_SIGNED, 32'hFFFF_FFF6, 8'h00);
		// Unsigned: zero, the maximum, values at and above 2^31, ten digits.
		send_request(itf_pkg::OP_UNSIGNED, 32'h0000_0000, 8'h00);
		send_request(itf_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 8'h00);
		send_request(itf_pkg::OP_UNSIGNED, 32'h8000_0000, 8'h00);
		send_request(itf_pkg::OP_UNSIGNED, 32'd1000000000, 8'h00);
		// Hex: zero, all ones, one digit, a carry into the second digit.
		send_request(itf_pkg::OP_HEX, 32'h0000_0000, 8'h00);
		send_request(itf_pkg::OP_HEX, 32'hFFFF_FFFF, 8'h00);
		send_request(itf_pkg::OP_HEX, 32'h0000_000F, 8'h00);
		send_request(itf_pkg::OP_HEX, 32'h0000_0010, 8'h00);
		// Tabs, with the ignored fields at both extremes.
		send_request(itf_pkg::OP_TAB, 32'h0000_0000, 8'h00);
		send_request(itf_pkg::OP_TAB, 32'hFFFF_FFFF, 8'hFF);
		// Unused opcodes produce nothing.
		send_request(OP_UNUSED_FIRST, 32'h1234_5678, 8'h31);
		send_request(OP_UNUSED_FIRST + 3'd1, 32'hFFFF_FFFF, 8'hFF);
		send_request(OP_UNUSED_LAST, 32'h0000_0000, 8'h00);

		random_burst(BURST_ITEMS);

		// Phase two: sender mostly idle, receiver mostly ready.
		send_idle_pct = 75;
		recv_idle_pct = 28;
		random_burst(BURST_ITEMS);

		// Phase three: no idling, with long receiver hold-offs to back up the input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = hold_requests + 1;
		random_burst(BURST_ITEMS / 2);
		if (holdoffs_done == hold_requests) begin
			hold_requests = hold_requests + 1;
		end
		random_burst(BURST_ITEMS / 2);

		// Drain: wait for every owed character, then some quiet cycles.
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_chars != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d with unused opcodes) and checked %0d characters,",
			requests_seen, ignored_requests, chars_checked);
		$display("across three idle mixes and %0d long receiver hold-offs; %0d mismatches.",
			holdoffs_done, fail_count);
		if (fail_count == 0 && pending_chars == 0) begin
			$display("** integer_text_formatter: PASSED **");
		end else begin
			$display("** integer_text_formatter: FAILED **");
		end
		$finish;
	end

endmodule
